[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Immediate-cycle implication check.
`define ASSERT_IMPL(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication check.
`define ASSERT_NEXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[hw/rtl/cpll_pkg.sv]
// Package with types and constants of the clock PLL.
`default_nettype none
package cpll_pkg;
    localparam int DacBits  = 16;
    localparam int FracBits = 16;
    typedef enum logic [1:0] {
        MODE_NOCLK = 2'd0, MODE_FREQ = 2'd1, MODE_SEEK = 2'd2, MODE_LOCK = 2'd3
    } mode_t;
    typedef enum logic [2:0] {
        CFG_NOMINAL = 3'd0, CFG_FOFFSET = 3'd1, CFG_POFFSET = 3'd2,
        CFG_WINDOW = 3'd3, CFG_START_DAC = 3'd4
    } cfg_idx_t;
    typedef enum logic [2:0] {
        ST_IDLE, ST_CALC1, ST_CALC2, ST_CALC3, ST_CALC4, ST_OUT
    } ctl_state_t;
    typedef struct packed {
        logic load;
        logic step1;
        logic step2;
        logic step3;
        logic step4;
    } dp_cmd_t;
    typedef struct packed {
        logic has_result;
    } dp_stat_t;
endpackage
`default_nettype wire

[hw/rtl/cpll_ctrl.sv]
// Controller state machine sequencing the datapath steps.
`default_nettype none
module cpll_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_fire,
    input  wire logic               out_fire,
    input  wire cpll_pkg::dp_stat_t stat,
    output cpll_pkg::dp_cmd_t       cmd,
    output logic                    in_ready,
    output logic                    out_valid
);
    cpll_pkg::ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= cpll_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cpll_pkg::ST_IDLE:  if (in_fire) state_next = cpll_pkg::ST_CALC1;
            cpll_pkg::ST_CALC1: state_next = cpll_pkg::ST_CALC2;
            cpll_pkg::ST_CALC2: state_next = cpll_pkg::ST_CALC3;
            cpll_pkg::ST_CALC3: state_next = cpll_pkg::ST_CALC4;
            cpll_pkg::ST_CALC4:
                state_next = stat.has_result ? cpll_pkg::ST_OUT : cpll_pkg::ST_IDLE;
            cpll_pkg::ST_OUT:   if (out_fire) state_next = cpll_pkg::ST_IDLE;
            default:            state_next = cpll_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.load  = in_fire;
        cmd.step1 = (state_reg == cpll_pkg::ST_CALC1);
        cmd.step2 = (state_reg == cpll_pkg::ST_CALC2);
        cmd.step3 = (state_reg == cpll_pkg::ST_CALC3);
        cmd.step4 = (state_reg == cpll_pkg::ST_CALC4);
        in_ready  = (state_reg == cpll_pkg::ST_IDLE);
        out_valid = (state_reg == cpll_pkg::ST_OUT);
    end
endmodule
`default_nettype wire

[hw/rtl/cpll_datapath.sv]
// Datapath of the clock PLL: interval and phase measurement and loop filters.
`default_nettype none
module cpll_datapath #(
    parameter int DAC_BITS  = cpll_pkg::DacBits,
    parameter int FRAC_BITS = cpll_pkg::FracBits
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cpll_pkg::dp_cmd_t   cmd,
    output cpll_pkg::dp_stat_t       stat,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_idx,
    input  wire logic [23:0]         cfg_data,
    input  wire logic                in_present,
    input  wire logic [63:0]         in_time,
    output logic [1:0]               lock_state,
    output logic signed [31:0]       freq_err,
    output logic signed [31:0]       phase_err,
    output logic [DAC_BITS-1:0]      dac_value,
    output logic signed [47:0]       raw_phase,
    output logic [31:0]              meas_interval
);
    localparam logic signed [63:0] DacMax = (64'sd1 <<< DAC_BITS) - 64'sd1;
    localparam logic signed [63:0] FOne   = 64'sd1 <<< FRAC_BITS;
    localparam logic [31:0] CVarNew = 32'((15 * FOne + 64'sd50) / 64'sd100);
    localparam logic [31:0] CVarOld = 32'((85 * FOne + 64'sd50) / 64'sd100);
    localparam logic [31:0] CB0 = 32'((3 * FOne + 64'sd5) / 64'sd10);
    localparam logic [31:0] CB1 = 32'((14 * FOne + 64'sd50) / 64'sd100);
    localparam logic [31:0] CB2 = 32'((41 * FOne + 64'sd50) / 64'sd100);
    localparam logic [31:0] CA1 = 32'((18 * FOne + 64'sd5) / 64'sd10);
    localparam logic [31:0] CA2 = 32'((8 * FOne + 64'sd5) / 64'sd10);
    localparam logic [63:0] VarMax = (64'd1 << 47) - 64'd1;
    localparam logic [63:0] SqLim  = VarMax / {32'd0, CVarNew};
    localparam logic signed [63:0] Lim47 = (64'sd1 <<< 47) - 64'sd1;
    localparam logic signed [63:0] Lim39 = (64'sd1 <<< 39) - 64'sd1;

    // Configuration registers.
    logic [23:0] nominal_reg;
    logic [15:0] foffset_reg;
    logic [20:0] poffset_reg;
    logic [19:0] window_reg;

    // Loop state.
    cpll_pkg::mode_t mode_reg;
    logic [63:0] ref_time_reg, nom_count_reg;
    logic [DAC_BITS-1:0] dac_reg, base_dac_reg;
    logic signed [39:0] integ_reg;
    logic [47:0] var_reg;
    logic signed [31:0] e1_reg, e2_reg;
    logic signed [47:0] y1_reg, y2_reg;

    // Per-item working registers.
    logic present_reg;
    logic [63:0] time_reg;
    logic signed [31:0] fe_reg, pe_reg;
    logic signed [47:0] raw_reg;
    logic [31:0] meas_reg;
    logic [1:0] lock_reg;
    logic has_res_reg;
    logic signed [63:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [63:0] ni_reg;
    logic [63:0] sq_reg;

    function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                                 input logic signed [63:0] lo,
                                                 input logic signed [63:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Rounded product v*c/2^FRAC_BITS, half away from zero.
    function automatic logic signed [63:0] rnd_mul(input logic signed [63:0] v,
                                                   input logic [31:0] c);
        logic [63:0] mag, r, lo;
        mag = v[63] ? 64'd0 - v : v;
        lo  = mag & (64'(FOne) - 64'd1);
        r   = (mag >> FRAC_BITS) * {32'd0, c}
            + ((lo * {32'd0, c} + (64'(FOne) >> 1)) >> FRAC_BITS);
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [DAC_BITS-1:0] clip(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = sat64(v, 64'sd0, DacMax);
        return s[DAC_BITS-1:0];
    endfunction

    logic signed [63:0] target;
    logic [63:0] diff, nc_new, praw;
    logic signed [63:0] fd, rawv, pev, abs_pe, y_sum, y_sat, dnext;
    logic [63:0] nv;
    assign target = 64'(nominal_reg) + 64'($signed(foffset_reg));
    assign diff   = time_reg - ref_time_reg;
    assign nc_new = nom_count_reg + target;
    assign praw   = nc_new - time_reg;

    always_comb begin
        fd     = sat64(target - 64'(meas_reg), -64'sd2147483648, 64'sd2147483647);
        rawv   = sat64($signed(praw), -Lim47 - 64'sd1, Lim47);
        pev    = sat64(64'(raw_reg) + 64'($signed(poffset_reg)),
                       -64'sd2147483648, 64'sd2147483647);
        abs_pe = pe_reg[31] ? -64'(pe_reg) : 64'(pe_reg);
        nv     = 64'(CVarNew) * sq_reg + $unsigned(p0_reg);
        y_sum  = p0_reg + p1_reg - p2_reg + p3_reg - p4_reg;
        y_sat  = sat64(y_sum, -Lim47 - 64'sd1, Lim47);
        dnext  = 64'(base_dac_reg) + 64'sd20 * 64'(pe_reg) + 64'sd9 * ni_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nominal_reg <= 24'd40000; foffset_reg <= '0; poffset_reg <= '0;
            window_reg <= 20'd100;
            mode_reg <= cpll_pkg::MODE_NOCLK;
            ref_time_reg <= '0; nom_count_reg <= '0;
            dac_reg <= clip(64'sd32768); base_dac_reg <= '0;
            integ_reg <= '0; var_reg <= 48'(100 * FOne);
            e1_reg <= '0; e2_reg <= '0; y1_reg <= '0; y2_reg <= '0;
            has_res_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    cpll_pkg::CFG_NOMINAL:   nominal_reg <= cfg_data;
                    cpll_pkg::CFG_FOFFSET:   foffset_reg <= cfg_data[15:0];
                    cpll_pkg::CFG_POFFSET:   poffset_reg <= cfg_data[20:0];
                    cpll_pkg::CFG_WINDOW:    window_reg <= cfg_data[19:0];
                    cpll_pkg::CFG_START_DAC: begin
                        if (mode_reg == cpll_pkg::MODE_NOCLK)
                            dac_reg <= clip(64'(cfg_data[15:0]));
                    end
                    default: ;
                endcase
            end
            if (cmd.load) begin
                present_reg <= in_present;
                time_reg <= in_time;
            end
            // Step 1: interval, raw phase and mode dispatch on clock loss or first sample.
            if (cmd.step1) begin
                fe_reg <= '0; pe_reg <= '0; raw_reg <= '0; meas_reg <= '0;
                lock_reg <= mode_reg;
                has_res_reg <= 1'b1;
                if (!present_reg) begin
                    mode_reg <= cpll_pkg::MODE_NOCLK;
                    lock_reg <= cpll_pkg::MODE_NOCLK;
                end else if (mode_reg == cpll_pkg::MODE_NOCLK) begin
                    mode_reg <= cpll_pkg::MODE_FREQ;
                    ref_time_reg <= time_reg;
                    has_res_reg <= 1'b0;
                end else begin
                    meas_reg <= (diff > 64'hFFFFFFFF) ? 32'hFFFFFFFF : diff[31:0];
                    ref_time_reg <= time_reg;
                    if (mode_reg != cpll_pkg::MODE_FREQ) begin
                        nom_count_reg <= nc_new;
                        raw_reg <= rawv[47:0];
                    end
                end
            end
            // Step 2: frequency and phase errors.
            if (cmd.step2 && present_reg && lock_reg != cpll_pkg::MODE_NOCLK) begin
                if (lock_reg != cpll_pkg::MODE_LOCK) fe_reg <= fd[31:0];
                if (lock_reg != cpll_pkg::MODE_FREQ) pe_reg <= pev[31:0];
            end
            if (cmd.step3 && has_res_reg && lock_reg != cpll_pkg::MODE_NOCLK) begin
                ni_reg <= sat64(64'(integ_reg) + 64'(pe_reg), -Lim39 - 64'sd1, Lim39);
                if (lock_reg == cpll_pkg::MODE_SEEK) begin
                    p0_reg <= rnd_mul(64'(var_reg), CVarOld);
                    sq_reg <= $unsigned(64'(pe_reg) * 64'(pe_reg));
                end else begin
                    p0_reg <= 64'($signed(CB0)) * 64'(pe_reg);
                    p1_reg <= 64'($signed(CB1)) * 64'(e1_reg);
                    p2_reg <= 64'($signed(CB2)) * 64'(e2_reg);
                    p3_reg <= rnd_mul(64'(y1_reg), CA1);
                    p4_reg <= rnd_mul(64'(y2_reg), CA2);
                end
            end
            // Step 4: update DAC, integrator, variance and mode.
            if (cmd.step4 && has_res_reg && lock_reg != cpll_pkg::MODE_NOCLK) begin
                unique case (lock_reg)
                    cpll_pkg::MODE_FREQ: begin
                        dac_reg <= clip(64'(dac_reg) + 64'sd20 * 64'(fe_reg));
                        if (fe_reg >= -32'sd1 && fe_reg <= 32'sd1) begin
                            nom_count_reg <= time_reg;
                            base_dac_reg <= clip(64'(dac_reg) + 64'sd20 * 64'(fe_reg));
                            integ_reg <= '0; var_reg <= 48'(100 * FOne);
                            mode_reg <= cpll_pkg::MODE_SEEK;
                        end
                    end
                    cpll_pkg::MODE_SEEK: begin
                        dac_reg <= clip(dnext);
                        if (clip(dnext) != '0 && 64'(clip(dnext)) != DacMax)
                            integ_reg <= ni_reg[39:0];
                        if (abs_pe > 64'(window_reg)) begin
                            mode_reg <= cpll_pkg::MODE_FREQ;
                        end else begin
                            if (sq_reg > SqLim || nv > VarMax) var_reg <= VarMax[47:0];
                            else var_reg <= nv[47:0];
                            if (sq_reg <= SqLim && nv < 64'(2 * FOne)) begin
                                base_dac_reg <= clip(dnext);
                                e1_reg <= '0; e2_reg <= '0; y1_reg <= '0; y2_reg <= '0;
                                mode_reg <= cpll_pkg::MODE_LOCK;
                            end
                        end
                    end
                    cpll_pkg::MODE_LOCK: begin
                        y2_reg <= y1_reg; y1_reg <= y_sat[47:0];
                        e2_reg <= e1_reg; e1_reg <= pe_reg;
                        dac_reg <= clip(64'(base_dac_reg) + rnd_mul(y_sat, 32'd1));
                        if (pe_reg > 32'sd2 || pe_reg < -32'sd2) begin
                            base_dac_reg <= clip(64'(base_dac_reg) + rnd_mul(y_sat, 32'd1));
                            integ_reg <= '0; var_reg <= 48'(100 * FOne);
                            mode_reg <= cpll_pkg::MODE_SEEK;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign stat.has_result = has_res_reg;
    assign lock_state    = lock_reg;
    assign freq_err      = fe_reg;
    assign phase_err     = pe_reg;
    assign dac_value     = dac_reg;
    assign raw_phase     = raw_reg;
    assign meas_interval = meas_reg;
endmodule
`default_nettype wire

[hw/rtl/clock_pll_acquire_and_lock_top.sv]
// Clock PLL acquire-and-lock: one time-stamp word in, at most one result word out.
// The s_ channel carries one sample per word: tuser is clock_present (0 means a
// timeout) and tdata is the 64-bit machine time.
// The m_ channel returns lock state, errors, DAC value, raw phase and interval.
// The first sample in the no-clock mode gives no result; every other word gives one.
// An accepted word runs through four datapath steps (states CALC1 to CALC4); its result
// word is then valid in state OUT and is held in the output registers until taken.
// The next word is accepted only after the previous one is through: once its result
// word is taken (m_tready high), or after the fourth step when the word gives no
// result; the four-step sequencer sets this pace, and receiver stalls delay it further.
// While m_tvalid is high and m_tready low, s_tready stays low.
// Reset (aresetn low, synchronous) loads register defaults, mode no clock
// and the DAC at 32768. Configuration writes go through cfg_we.
`default_nettype none
module clock_pll_acquire_and_lock_top #(
    parameter int DAC_BITS  = cpll_pkg::DacBits,
    parameter int FRAC_BITS = cpll_pkg::FracBits
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // machine_time[63:0]
    input  wire logic         s_tuser,   // clock_present
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // lock_state[1:0], freq_err[33:2], phase_err[65:34],
    // dac_value, raw_phase (48), measured_interval (32), zero pad
    output logic [167:0]      m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_idx,
    input  wire logic [23:0]  cfg_data
);
    cpll_pkg::dp_cmd_t  cmd;
    cpll_pkg::dp_stat_t stat;
    logic in_fire, out_fire;
    logic [1:0] lock_state;
    logic signed [31:0] fe, pe;
    logic [DAC_BITS-1:0] dac;
    logic signed [47:0] raw;
    logic [31:0] meas;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    cpll_ctrl u_ctrl (
        .aclk, .aresetn, .in_fire, .out_fire, .stat, .cmd,
        .in_ready(s_tready), .out_valid(m_tvalid)
    );

    cpll_datapath #(.DAC_BITS(DAC_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk, .aresetn, .cmd, .stat, .cfg_we, .cfg_idx, .cfg_data,
        .in_present(s_tuser), .in_time(s_tdata),
        .lock_state, .freq_err(fe), .phase_err(pe), .dac_value(dac),
        .raw_phase(raw), .meas_interval(meas)
    );

    logic [15:0] dac16;
    assign dac16 = 16'(dac);
    assign m_tdata = {6'd0, meas, raw, dac16, pe, fe, lock_state};

`include "assert_macros.svh"
    `ASSERT_IMPL(a_no_both, aclk, aresetn, m_tvalid, !s_tready)
    `ASSERT_NEXT(a_busy, aclk, aresetn, in_fire, !s_tready)
    `ASSERT_NEXT(a_no_early, aclk, aresetn, in_fire, !m_tvalid)
endmodule
`default_nettype wire

[sim/clock_pll_acquire_and_lock_top_tb.sv]
// Self-checking testbench for the clock PLL acquire-and-lock block.
`default_nettype none
module clock_pll_acquire_and_lock_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DacTop    = 65535;
    localparam longint FracOne   = 65536;
    localparam longint VarNewK   = (15 * FracOne + 50) / 100;
    localparam longint VarOldK   = (85 * FracOne + 50) / 100;
    localparam longint B0K       = (3 * FracOne + 5) / 10;
    localparam longint B1K       = (14 * FracOne + 50) / 100;
    localparam longint B2K       = (41 * FracOne + 50) / 100;
    localparam longint A1K       = (18 * FracOne + 5) / 10;
    localparam longint A2K       = (8 * FracOne + 5) / 10;
    localparam longint Lim47     = (longint'(1) <<< 47) - 1;
    localparam longint Lim39     = (longint'(1) <<< 39) - 1;
    localparam longint Int32Max  = 2147483647;
    localparam longint Int32Min  = -64'sd2147483648;
    localparam int     CycleLimit = 400000;
    localparam int     DrainCycles = 16;

    typedef struct {
        logic [1:0]  lock;
        logic [31:0] freq_err;
        logic [31:0] phase_err;
        logic [15:0] dac;
        logic [47:0] raw;
        logic [31:0] interval;
    } pll_word_t;

    typedef struct {
        bit        present;
        bit [63:0] stamp;
        bit        known;
        bit [15:0] known_dac;
    } sample_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_idx;
    logic [23:0]  cfg_data;

    pll_word_t expected_words[$];
    int        fail_count = 0;
    int        cycle_count = 0;
    bit        steady = 0;

    // Predictor copy of the registers and loop state.
    longint    nominal_q, foffset_q, poffset_q, window_q, start_dac_q;
    cpll_pkg::mode_t pll_mode;
    bit [63:0] ref_stamp, nominal_stamp;
    longint    dac_q, base_q, integ_q, variance_q;
    longint    err_hist [2];
    longint    out_hist [2];

    clock_pll_acquire_and_lock_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Multiply by a Q16 coefficient, rounding half away from zero.
    function automatic longint q16_scale(longint v, longint k);
        longint mag, r;
        mag = v < 0 ? -v : v;
        r = (mag >>> 16) * k + (((mag & (FracOne - 1)) * k + FracOne / 2) >>> 16);
        return v < 0 ? -r : r;
    endfunction

    function automatic void reset_pll();
        nominal_q = 40000; foffset_q = 0; poffset_q = 0; window_q = 100; start_dac_q = 32768;
        pll_mode = cpll_pkg::MODE_NOCLK;
        ref_stamp = 0; nominal_stamp = 0;
        dac_q = start_dac_q; base_q = 0; integ_q = 0; variance_q = 100 * FracOne;
        err_hist[0] = 0; err_hist[1] = 0; out_hist[0] = 0; out_hist[1] = 0;
    endfunction

    function automatic void start_phase_seek();
        base_q = dac_q;
        integ_q = 0;
        variance_q = 100 * FracOne;
    endfunction

    // Advance the loop by one sample; returns 1 when a result word is produced.
    function automatic bit step_pll(bit present, bit [63:0] stamp, output pll_word_t w);
        longint target, interval, fdiff, fe, pe, raw, ni, sq, nv, y;
        bit [63:0] diff;
        cpll_pkg::mode_t ran;
        fe = 0; pe = 0; raw = 0; interval = 0;
        ran = cpll_pkg::MODE_NOCLK;
        if (!present) begin
            pll_mode = cpll_pkg::MODE_NOCLK;
        end else if (pll_mode == cpll_pkg::MODE_NOCLK) begin
            pll_mode = cpll_pkg::MODE_FREQ;
            ref_stamp = stamp;
            return 0;
        end else begin
            diff = stamp - ref_stamp;
            target = nominal_q + foffset_q;
            interval = diff > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : longint'(diff);
            ref_stamp = stamp;
            fdiff = clampv(target - interval, Int32Min, Int32Max);
            ran = pll_mode;
            if (pll_mode == cpll_pkg::MODE_FREQ) begin
                fe = fdiff;
                dac_q = clampv(dac_q + 20 * fe, 0, DacTop);
                if (fe >= -1 && fe <= 1) begin
                    nominal_stamp = stamp;
                    start_phase_seek();
                    pll_mode = cpll_pkg::MODE_SEEK;
                end
            end else begin
                nominal_stamp = nominal_stamp + target;
                raw = clampv(longint'(nominal_stamp - stamp), -Lim47 - 1, Lim47);
                pe = clampv(raw + poffset_q, Int32Min, Int32Max);
                if (pll_mode == cpll_pkg::MODE_SEEK) begin
                    fe = fdiff;
                    ni = clampv(integ_q + pe, -Lim39 - 1, Lim39);
                    dac_q = clampv(base_q + 20 * pe + 9 * ni, 0, DacTop);
                    // The integrator holds while the DAC is pinned at a rail.
                    if (dac_q != 0 && dac_q != DacTop) integ_q = ni;
                    if ((pe < 0 ? -pe : pe) > window_q) begin
                        pll_mode = cpll_pkg::MODE_FREQ;
                    end else begin
                        sq = pe * pe;
                        if (sq > Lim47 / VarNewK) begin
                            nv = Lim47;
                        end else begin
                            nv = VarNewK * sq + q16_scale(variance_q, VarOldK);
                            if (nv > Lim47) nv = Lim47;
                        end
                        variance_q = nv;
                        if (nv < 2 * FracOne) begin
                            base_q = dac_q;
                            err_hist[0] = 0; err_hist[1] = 0;
                            out_hist[0] = 0; out_hist[1] = 0;
                            pll_mode = cpll_pkg::MODE_LOCK;
                        end
                    end
                end else begin
                    y = B0K * pe + B1K * err_hist[0] - B2K * err_hist[1]
                        + q16_scale(out_hist[0], A1K) - q16_scale(out_hist[1], A2K);
                    y = clampv(y, -Lim47 - 1, Lim47);
                    out_hist[1] = out_hist[0]; out_hist[0] = y;
                    err_hist[1] = err_hist[0]; err_hist[0] = pe;
                    dac_q = clampv(base_q + q16_scale(y, 1), 0, DacTop);
                    if (pe > 2 || pe < -2) begin
                        start_phase_seek();
                        pll_mode = cpll_pkg::MODE_SEEK;
                    end
                end
            end
        end
        w.lock = ran;
        w.freq_err = fe[31:0];
        w.phase_err = pe[31:0];
        w.dac = dac_q[15:0];
        w.raw = raw[47:0];
        w.interval = interval[31:0];
        return 1;
    endfunction

    task automatic write_reg(cpll_pkg::cfg_idx_t idx, longint value);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= value[23:0];
        @(posedge aclk);
        cfg_we <= 0;
        case (idx)
            cpll_pkg::CFG_NOMINAL:   nominal_q = value;
            cpll_pkg::CFG_FOFFSET:   foffset_q = value;
            cpll_pkg::CFG_POFFSET:   poffset_q = value;
            cpll_pkg::CFG_WINDOW:    window_q = value;
            cpll_pkg::CFG_START_DAC: begin
                start_dac_q = value;
                if (pll_mode == cpll_pkg::MODE_NOCLK) dac_q = start_dac_q;
            end
            default: ;
        endcase
    endtask

    // Stop sending and let every expected word drain before touching registers.
    task automatic wait_drained();
        s_tvalid <= 0;
        @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic send_sample(bit present, bit [63:0] stamp, bit known, bit [15:0] kdac);
        pll_word_t w;
        if (!steady && $urandom_range(99) < 8) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= present;
        s_tdata <= stamp;
        do @(posedge aclk); while (!s_tready);
        if (step_pll(present, stamp, w)) begin
            if (known) begin
                w.lock = cpll_pkg::MODE_NOCLK; w.freq_err = 0; w.phase_err = 0;
                w.dac = kdac; w.raw = 0; w.interval = 0;
            end
            expected_words.push_back(w);
        end
    endtask

    task automatic program_all(longint nom, longint fo, longint po, longint win, longint sd);
        write_reg(cpll_pkg::CFG_NOMINAL, nom);
        write_reg(cpll_pkg::CFG_FOFFSET, fo);
        write_reg(cpll_pkg::CFG_POFFSET, po);
        write_reg(cpll_pkg::CFG_WINDOW, win);
        write_reg(cpll_pkg::CFG_START_DAC, sd);
    endtask

    always @(posedge aclk) begin
        if (!aresetn || !steady) m_tready <= aresetn && ($urandom_range(99) >= 8);
        else m_tready <= 1;
    end

    always @(posedge aclk) begin
        pll_word_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                fail_count++;
            end else begin
                e = expected_words.pop_front();
                if (m_tdata[1:0] !== e.lock) begin
                    $error("lock_state exp %0d got %0d", e.lock, m_tdata[1:0]); fail_count++;
                end
                if (m_tdata[33:2] !== e.freq_err) begin
                    $error("freq_err exp %0d got %0d", $signed(e.freq_err),
                           $signed(m_tdata[33:2])); fail_count++;
                end
                if (m_tdata[65:34] !== e.phase_err) begin
                    $error("phase_err exp %0d got %0d", $signed(e.phase_err),
                           $signed(m_tdata[65:34])); fail_count++;
                end
                if (m_tdata[81:66] !== e.dac) begin
                    $error("dac_value exp %0d got %0d", e.dac, m_tdata[81:66]); fail_count++;
                end
                if (m_tdata[129:82] !== e.raw) begin
                    $error("raw_phase exp %0d got %0d", $signed(e.raw),
                           $signed(m_tdata[129:82])); fail_count++;
                end
                if (m_tdata[161:130] !== e.interval) begin
                    $error("measured_interval exp %0d got %0d", e.interval,
                           m_tdata[161:130]); fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    sample_row_t directed [15] = '{
        '{0, 64'd0, 1, 16'd32768},           // timeout straight after reset
        '{1, 64'd0, 0, 16'd0},               // first sample only takes the reference
        '{1, 64'd40000, 0, 16'd0},           // exact interval moves to phase seek
        '{1, 64'd80000, 0, 16'd0},
        '{1, 64'd120001, 0, 16'd0},
        '{1, 64'd160001, 0, 16'd0},
        '{1, 64'd160500, 0, 16'd0},          // phase beyond the window
        '{1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 16'd0}, // interval saturates
        '{1, 64'd0, 0, 16'd0},
        '{1, 64'd40000, 0, 16'd0},
        '{1, 64'h8000_0000_0000_0000, 0, 16'd0},
        '{0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 16'd0},
        '{1, 64'h5555_5555_5555_5555, 0, 16'd0},
        '{1, 64'hAAAA_AAAA_AAAA_AAAA, 0, 16'd0},
        '{0, 64'd0, 0, 16'd0}
    };

    initial begin
        longint cfgs [4][5];
        longint target, jit;
        bit [63:0] stamp;
        int pick;
        aresetn = 0; s_tvalid = 0; s_tdata = 0; s_tuser = 0;
        cfg_we = 0; cfg_idx = 0; cfg_data = 0;
        reset_pll();
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (directed[i])
            send_sample(directed[i].present, directed[i].stamp, directed[i].known,
                        directed[i].known_dac);

        cfgs[0] = '{1000, 0, 0, 100, 32768};
        cfgs[1] = '{16777215, 32767, -1048576, 1048575, 0};
        cfgs[2] = '{1, -32768, 1048575, 0, 65535};
        cfgs[3] = '{5000, -3, 1, 50, 12345};
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            program_all(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2], cfgs[ph][3], cfgs[ph][4]);
            steady = (ph == 0);
            target = nominal_q + foffset_q;
            stamp = {$urandom, $urandom};
            for (int n = 0; n < 120; n++) begin
                if (n == 60) wait_drained();
                pick = $urandom_range(99);
                if (pick < 3) begin
                    send_sample(0, {$urandom, $urandom}, 0, 0);
                end else begin
                    if (pick < 6) stamp = {$urandom, $urandom};
                    else begin
                        pick = $urandom_range(99);
                        if (pick < 80) jit = 0;
                        else if (pick < 93) jit = longint'($urandom_range(4)) - 2;
                        else jit = longint'($urandom_range(200)) - 100;
                        stamp = stamp + target + jit;
                    end
                    send_sample(1, stamp, 0, 0);
                end
            end
            // A final timeout leaves the loop without a clock for the next start value.
            send_sample(0, stamp, 0, 0);
        end
        steady = 0;
        wait_drained();
        if (fail_count == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
